// ----- rtl/fta_pkg.sv -----
// Shared types and constants for frame_timestamp_admission.
// Event codes, result status codes, register indexes and field widths.
`timescale 1ns / 1ps

package fta_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 48;
  localparam int SEGCT_W  = 47;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int PERIOD_W = 20;
  localparam int TOL_W    = 20;
  localparam int THR_W    = 24;
  localparam int LIMIT_W  = 26;

  typedef enum logic [FUNC_W-1:0] {
    FN_START        = 3'd0,
    FN_END          = 3'd1,
    FN_BEGIN_PREVIEW = 3'd2,
    FN_BEGIN_ABS    = 3'd3,
    FN_ADMIT        = 3'd4,
    FN_SUCCESSOR    = 3'd5,
    FN_RESET_STATS  = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FAILED       = 3'd1,
    ST_REJECT_LATE  = 3'd2,
    ST_REJECT_EARLY = 3'd3,
    ST_NO_OBSERVER  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_PERIOD = 3'd0,
    CFG_TOLERANCE    = 3'd1,
    CFG_LATE_THR     = 3'd2,
    CFG_EARLY_THR    = 3'd3,
    CFG_CATCHUP_LIM  = 3'd4,
    CFG_OBSERVER     = 3'd5
  } cfg_idx_t;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 20'd33333;
  localparam logic [TOL_W-1:0]    TOL_RST     = 20'd1000;
  localparam logic [THR_W-1:0]    LATE_RST    = 24'd500000;
  localparam logic [THR_W-1:0]    EARLY_RST   = 24'd500000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 26'd5000000;

endpackage

// ----- rtl/fta_in_if.sv -----
// Input channel of frame_timestamp_admission: one event item per handshake.
// Depends on fta_pkg for field widths.
`timescale 1ns / 1ps

interface fta_in_if;
  logic                            valid;
  logic                            ready;
  logic [fta_pkg::FUNC_W-1:0]      func;
  logic [fta_pkg::TIME_W-1:0]      wall_time_us;
  logic [fta_pkg::TIME_W-1:0]      frame_mt_us;
  logic [fta_pkg::SEGCT_W-1:0]     seg_ct_start_us;
  logic [fta_pkg::TIME_W-1:0]      seg_mt_start_us;

  modport source (output valid, func, wall_time_us, frame_mt_us, seg_ct_start_us,
                  seg_mt_start_us, input ready);
  modport sink (input valid, func, wall_time_us, frame_mt_us, seg_ct_start_us,
                seg_mt_start_us, output ready);
endinterface

// ----- rtl/fta_out_if.sv -----
// Result channel of frame_timestamp_admission: one result item per event.
// Depends on fta_pkg for field widths.
`timescale 1ns / 1ps

interface fta_out_if;
  logic                              valid;
  logic                              ready;
  logic [fta_pkg::STATUS_W-1:0]      status;
  logic signed [fta_pkg::TIME_W-1:0] ct_out_us;
  logic signed [fta_pkg::TIME_W-1:0] lag_us;
  logic                              in_catch_up;
  logic                              restart_needed;
  logic [fta_pkg::CNT_W-1:0]         seg_num;
  logic [fta_pkg::CNT_W-1:0]         commit_generation;
  logic [fta_pkg::CNT_W-1:0]         admitted_count;
  logic [fta_pkg::CNT_W-1:0]         late_count;
  logic [fta_pkg::CNT_W-1:0]         early_count;
  logic [fta_pkg::CNT_W-1:0]         catchup_episodes;
  logic signed [fta_pkg::TIME_W-1:0] peak_lag_us;

  modport source (output valid, status, ct_out_us, lag_us, in_catch_up, restart_needed,
                  seg_num, commit_generation, admitted_count, late_count, early_count,
                  catchup_episodes, peak_lag_us, input ready);
  modport sink (input valid, status, ct_out_us, lag_us, in_catch_up, restart_needed,
                seg_num, commit_generation, admitted_count, late_count, early_count,
                catchup_episodes, peak_lag_us, output ready);
endinterface

// ----- rtl/frame_timestamp_admission.sv -----
// Video frame timeline admission: session, segment mapping and frame admission.
// Depends on fta_pkg, fta_in_if and fta_out_if.
//
// Usage:
//   in_ch carries one event item (func, wall/media time, absolute segment
//   start). out_ch returns exactly one result item per event, in order.
//   cfg_we/cfg_idx/cfg_data write the six configuration registers; write only while
//   no item is in flight.
// Pipeline: the input register loads at the accept and the result register
//   loads from it when it advances; out_ch.valid rises once the result
//   register holds the item. Throughput: one item per cycle while out_ch.ready
//   is high; the timeline state is updated in the same cycle the result is
//   registered, so the next item sees it immediately.
// Stall: when out_ch.ready is low the result register holds and the input
//   register fills; in_ch.ready drops only once both are occupied.
// Reset (rst, synchronous): pipeline empty, session idle, no mapping, no
//   segment pending, next segment id 1, counters and peak lag zero,
//   registers at their defaults.
`timescale 1ns / 1ps

module frame_timestamp_admission (
  input  logic                              clk,
  input  logic                              rst,
  fta_in_if.sink                            in_ch,
  fta_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fta_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fta_pkg::*;

  // configuration
  logic [PERIOD_W-1:0] period_cfg;
  logic [TOL_W-1:0]    tolerance;
  logic [THR_W-1:0]    late_thr;
  logic [THR_W-1:0]    early_thr;
  logic [LIMIT_W-1:0]  catchup_limit;
  logic                observer;

  // input register
  logic                s1_valid;
  logic [FUNC_W-1:0]   s1_func;
  logic [TIME_W-1:0]   s1_wall;
  logic [TIME_W-1:0]   s1_mt;
  logic [SEGCT_W-1:0]  s1_sct;
  logic [TIME_W-1:0]   s1_smt;
  logic                adv;

  // timeline state
  logic              session_active, session_active_next;
  logic [TIME_W-1:0] epoch_time, epoch_time_next;
  logic [TIME_W-1:0] cursor_time, cursor_time_next;
  logic              mapping_valid, mapping_valid_next;
  logic [TIME_W-1:0] map_offset, map_offset_next;
  logic              pending_valid, pending_valid_next;
  logic [CNT_W-1:0]  pending_id, pending_id_next;
  logic [CNT_W-1:0]  next_id, next_id_next;
  logic [CNT_W-1:0]  owner_id, owner_id_next;
  logic              commit_waiting, commit_waiting_next;
  logic [CNT_W-1:0]  commit_seq, commit_seq_next;
  logic              was_catching_up, was_catching_up_next;
  logic [CNT_W-1:0]  admitted_cnt, admitted_cnt_next;
  logic [CNT_W-1:0]  late_cnt, late_cnt_next;
  logic [CNT_W-1:0]  early_cnt, early_cnt_next;
  logic [CNT_W-1:0]  catchup_cnt, catchup_cnt_next;
  logic [TIME_W-1:0] peak_lag, peak_lag_next;

  // datapath
  logic [TIME_W-1:0]        wall_rel;
  logic [TIME_W-1:0]        expected;
  logic [TIME_W-1:0]        frame_ct;
  logic [TIME_W-1:0]        delta;
  logic signed [TIME_W:0]   delta_x;
  logic signed [TIME_W:0]   tol_x;
  logic signed [TIME_W:0]   late_x;
  logic signed [TIME_W:0]   early_x;
  logic [TIME_W-1:0]        lag_keep;
  logic [TIME_W-1:0]        lag_snap;
  logic [TIME_W-1:0]        lag_frame;
  logic                     within_tol;
  logic                     too_late;
  logic                     too_early;

  // result of the current item
  status_t           res_status;
  logic [TIME_W-1:0] res_ct;
  logic [TIME_W-1:0] res_lag;
  logic [CNT_W-1:0]  res_seg;
  logic              res_catch;
  logic              res_restart;

  // result register
  logic                     o_valid;
  status_t                  o_status;
  logic signed [TIME_W-1:0] o_ct;
  logic signed [TIME_W-1:0] o_lag;
  logic                     o_catch;
  logic                     o_restart;
  logic [CNT_W-1:0]         o_seg;
  logic [CNT_W-1:0]         o_gen;
  logic [CNT_W-1:0]         o_admitted;
  logic [CNT_W-1:0]         o_late;
  logic [CNT_W-1:0]         o_early;
  logic [CNT_W-1:0]         o_catchups;
  logic signed [TIME_W-1:0] o_peak;

  assign adv         = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_cfg    <= PERIOD_RST;
      tolerance     <= TOL_RST;
      late_thr      <= LATE_RST;
      early_thr     <= EARLY_RST;
      catchup_limit <= LIMIT_RST;
      observer      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_FRAME_PERIOD: period_cfg    <= cfg_data[PERIOD_W-1:0];
        CFG_TOLERANCE:    tolerance     <= cfg_data[TOL_W-1:0];
        CFG_LATE_THR:     late_thr      <= cfg_data[THR_W-1:0];
        CFG_EARLY_THR:    early_thr     <= cfg_data[THR_W-1:0];
        CFG_CATCHUP_LIM:  catchup_limit <= cfg_data[LIMIT_W-1:0];
        CFG_OBSERVER:     observer      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func <= in_ch.func;
      s1_wall <= in_ch.wall_time_us;
      s1_mt   <= in_ch.frame_mt_us;
      s1_sct  <= in_ch.seg_ct_start_us;
      s1_smt  <= in_ch.seg_mt_start_us;
    end
  end

  // frame timing arithmetic, 48-bit wrapping; tolerance and threshold compares are 49-bit signed
  assign wall_rel  = s1_wall - epoch_time;
  assign expected  = cursor_time + {{(TIME_W-PERIOD_W){1'b0}}, period_cfg};
  assign frame_ct  = map_offset + s1_mt;
  assign delta     = frame_ct - expected;
  assign delta_x   = $signed({delta[TIME_W-1], delta});
  assign tol_x     = $signed({{(TIME_W+1-TOL_W){1'b0}}, tolerance});
  assign late_x    = $signed({{(TIME_W+1-THR_W){1'b0}}, late_thr});
  assign early_x   = $signed({{(TIME_W+1-THR_W){1'b0}}, early_thr});
  assign within_tol = (delta_x <= tol_x) && (delta_x >= -tol_x);
  assign too_late   = delta_x < -late_x;
  assign too_early  = delta_x > early_x;
  assign lag_keep  = wall_rel - cursor_time;
  assign lag_snap  = wall_rel - expected;
  assign lag_frame = wall_rel - frame_ct;

  always_comb begin
    session_active_next  = session_active;
    epoch_time_next      = epoch_time;
    cursor_time_next     = cursor_time;
    mapping_valid_next   = mapping_valid;
    map_offset_next      = map_offset;
    pending_valid_next   = pending_valid;
    pending_id_next      = pending_id;
    next_id_next         = next_id;
    owner_id_next        = owner_id;
    commit_waiting_next  = commit_waiting;
    commit_seq_next      = commit_seq;
    was_catching_up_next = was_catching_up;
    admitted_cnt_next    = admitted_cnt;
    late_cnt_next        = late_cnt;
    early_cnt_next       = early_cnt;
    catchup_cnt_next     = catchup_cnt;
    peak_lag_next        = peak_lag;
    res_status           = ST_OK;
    res_ct               = '0;
    res_lag              = lag_keep;
    res_seg              = owner_id;

    case (func_t'(s1_func))
      FN_START: begin
        if (session_active) begin
          res_status = ST_FAILED;
        end else begin
          epoch_time_next      = s1_wall;
          cursor_time_next     = '0;
          mapping_valid_next   = 1'b0;
          session_active_next  = 1'b1;
          was_catching_up_next = 1'b0;
          res_lag              = '0;
        end
      end
      FN_END: begin
        if (session_active) begin
          session_active_next = 1'b0;
          epoch_time_next     = '0;
          cursor_time_next    = '0;
          mapping_valid_next  = 1'b0;
          pending_valid_next  = 1'b0;
          res_lag             = s1_wall;
        end
      end
      FN_BEGIN_PREVIEW: begin
        if (pending_valid) begin
          res_status = ST_FAILED;
        end else begin
          res_seg            = next_id;
          next_id_next       = next_id + 1'b1;
          pending_id_next    = next_id;
          pending_valid_next = 1'b1;
          mapping_valid_next = 1'b0;
        end
      end
      FN_BEGIN_ABS: begin
        if (pending_valid) begin
          res_status = ST_FAILED;
        end else begin
          res_seg            = next_id;
          next_id_next       = next_id + 1'b1;
          map_offset_next    = {1'b0, s1_sct} - s1_smt;
          mapping_valid_next = 1'b1;
        end
      end
      FN_ADMIT: begin
        if (!session_active) begin
          res_status = ST_FAILED;
        end else if (pending_valid) begin
          if (!observer) begin
            res_status = ST_NO_OBSERVER;
          end else begin
            // first frame locks the mapping and lands exactly on its slot
            map_offset_next     = wall_rel - s1_mt;
            mapping_valid_next  = 1'b1;
            cursor_time_next    = wall_rel;
            owner_id_next       = pending_id;
            res_seg             = pending_id;
            commit_waiting_next = 1'b1;
            pending_valid_next  = 1'b0;
            res_ct              = wall_rel;
            res_lag             = '0;
            admitted_cnt_next   = admitted_cnt + 1'b1;
            if ($signed(peak_lag) < 0) begin
              peak_lag_next = '0;
            end
            was_catching_up_next = 1'b0;
          end
        end else if (!mapping_valid) begin
          res_status = ST_FAILED;
        end else if (within_tol) begin
          res_ct            = expected;
          cursor_time_next  = expected;
          res_lag           = lag_snap;
          admitted_cnt_next = admitted_cnt + 1'b1;
          if ($signed(lag_snap) > $signed(peak_lag)) begin
            peak_lag_next = lag_snap;
          end
          if ($signed(lag_snap) > 0) begin
            if (!was_catching_up) begin
              was_catching_up_next = 1'b1;
              catchup_cnt_next     = catchup_cnt + 1'b1;
            end
          end else begin
            was_catching_up_next = 1'b0;
          end
        end else if (too_late) begin
          res_status    = ST_REJECT_LATE;
          late_cnt_next = late_cnt + 1'b1;
        end else if (too_early) begin
          res_status     = ST_REJECT_EARLY;
          early_cnt_next = early_cnt + 1'b1;
        end else begin
          res_ct            = frame_ct;
          cursor_time_next  = frame_ct;
          res_lag           = lag_frame;
          admitted_cnt_next = admitted_cnt + 1'b1;
        end
      end
      FN_SUCCESSOR: begin
        if (commit_waiting) begin
          commit_waiting_next = 1'b0;
          commit_seq_next     = commit_seq + 1'b1;
        end
      end
      FN_RESET_STATS: begin
        admitted_cnt_next    = '0;
        late_cnt_next        = '0;
        early_cnt_next       = '0;
        catchup_cnt_next     = '0;
        peak_lag_next        = '0;
        was_catching_up_next = 1'b0;
      end
      default: begin
        res_status = ST_FAILED;
      end
    endcase
  end

  assign res_catch   = $signed(res_lag) > 0;
  assign res_restart = $signed(res_lag) >
                       $signed({{(TIME_W-LIMIT_W){1'b0}}, catchup_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      epoch_time      <= '0;
      cursor_time     <= '0;
      mapping_valid   <= 1'b0;
      map_offset      <= '0;
      pending_valid   <= 1'b0;
      pending_id      <= '0;
      next_id         <= {{(CNT_W-1){1'b0}}, 1'b1};
      owner_id        <= '0;
      commit_waiting  <= 1'b0;
      commit_seq      <= '0;
      was_catching_up <= 1'b0;
      admitted_cnt    <= '0;
      late_cnt        <= '0;
      early_cnt       <= '0;
      catchup_cnt     <= '0;
      peak_lag        <= '0;
    end else if (adv) begin
      session_active  <= session_active_next;
      epoch_time      <= epoch_time_next;
      cursor_time     <= cursor_time_next;
      mapping_valid   <= mapping_valid_next;
      map_offset      <= map_offset_next;
      pending_valid   <= pending_valid_next;
      pending_id      <= pending_id_next;
      next_id         <= next_id_next;
      owner_id        <= owner_id_next;
      commit_waiting  <= commit_waiting_next;
      commit_seq      <= commit_seq_next;
      was_catching_up <= was_catching_up_next;
      admitted_cnt    <= admitted_cnt_next;
      late_cnt        <= late_cnt_next;
      early_cnt       <= early_cnt_next;
      catchup_cnt     <= catchup_cnt_next;
      peak_lag        <= peak_lag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_status   <= res_status;
      o_ct       <= $signed(res_ct);
      o_lag      <= $signed(res_lag);
      o_catch    <= res_catch;
      o_restart  <= res_restart;
      o_seg      <= res_seg;
      o_gen      <= commit_seq_next;
      o_admitted <= admitted_cnt_next;
      o_late     <= late_cnt_next;
      o_early    <= early_cnt_next;
      o_catchups <= catchup_cnt_next;
      o_peak     <= $signed(peak_lag_next);
    end
  end

  assign out_ch.valid             = o_valid;
  assign out_ch.status            = o_status;
  assign out_ch.ct_out_us         = o_ct;
  assign out_ch.lag_us            = o_lag;
  assign out_ch.in_catch_up       = o_catch;
  assign out_ch.restart_needed    = o_restart;
  assign out_ch.seg_num           = o_seg;
  assign out_ch.commit_generation = o_gen;
  assign out_ch.admitted_count    = o_admitted;
  assign out_ch.late_count        = o_late;
  assign out_ch.early_count       = o_early;
  assign out_ch.catchup_episodes  = o_catchups;
  assign out_ch.peak_lag_us       = o_peak;

  // a preview segment waiting for its first frame never coexists with a mapping
  a_pending_excl: assert property (@(posedge clk) disable iff (rst)
    !(pending_valid && mapping_valid))
    else $error("pending segment and valid mapping at once");

  // outside a session the timeline origin and cursor stay cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !session_active |-> (epoch_time == '0) && (cursor_time == '0))
    else $error("epoch or cursor nonzero without a session");

  // a rejected or failed frame carries no channel time
  a_reject_no_ct: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_status != ST_OK) |-> (o_ct == '0))
    else $error("non-ok result with a channel time");

  // the catch-up flag agrees with the sign of the reported lag
  a_catch_sign: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_catch == (o_lag > 0)))
    else $error("catch-up flag disagrees with lag");

endmodule
